// File: src/esv_pkg.sv
// esv_pkg: shared types and constants for the segment validator
// used by esv_front, esv_queue, esv_back and elf_segment_validator_top
package esv_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LOAD_ADDR = 1'b0,
    CFG_GUEST_SIZE    = 1'b1
  } cfg_idx_t;

  localparam logic [31:0] SEG_TYPE_LOAD = 32'd1;

  typedef enum logic [4:0] {
    ST_OK              = 5'd0,
    ST_SKIPPED         = 5'd1,
    ST_VADDR_LOW       = 5'd2,
    ST_UNORDERED       = 5'd3,
    ST_BAD_ALIGN       = 5'd4,
    ST_START_LOW       = 5'd5,
    ST_OVERLAP         = 5'd6,
    ST_VADDR_HIGH      = 5'd7,
    ST_FILE_OVERFLOW   = 5'd8,
    ST_FILE_END_HIGH   = 5'd9,
    ST_MEMSZ_SMALL     = 5'd10,
    ST_MEM_OVERFLOW    = 5'd11,
    ST_ALIGNUP_OVERFLOW = 5'd12,
    ST_END_HIGH        = 5'd13,
    ST_START_UNALIGNED = 5'd14,
    ST_END_UNALIGNED   = 5'd15,
    ST_WRITE_EXEC      = 5'd16,
    ST_ENTRY_BAD       = 5'd17,
    ST_ENTRY_OK        = 5'd18,
    ST_ALREADY_FAILED  = 5'd19
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              is_begin;
    logic              entry_bad;
    logic              skip;
    logic              va_low;
    logic              align_bad;
    logic              start_low;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] end_addr;
    status_t           mid_code;
    status_t           late_code;
    logic [2:0]        prot;
  } item_t;

endpackage

// File: src/esv_front.sv
// esv_front: two-stage classifier, does every check that needs no running state
// depends on esv_pkg
module esv_front #(
  parameter int unsigned PAGE_SIZE = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [63:0]                in_entry_addr,
  input  logic [31:0]                in_seg_type,
  input  logic [31:0]                in_seg_flags,
  input  logic [63:0]                in_seg_vaddr,
  input  logic [63:0]                in_seg_filesz,
  input  logic [63:0]                in_seg_memsz,
  input  logic [63:0]                in_seg_align,
  input  logic [esv_pkg::ADDR_W-1:0] min_load_addr,
  input  logic [esv_pkg::ADDR_W-1:0] guest_size,
  output logic                       q_valid,
  input  logic                       q_ready,
  output esv_pkg::item_t             q_item
);

  localparam logic [63:0] PAGE_MASK = 64'(PAGE_SIZE - 1);

  logic        a_vld_r;
  logic        a_begin_r;
  logic        a_entry_bad_r;
  logic        a_skip_r;
  logic [63:0] a_va_r;
  logic [64:0] a_sumf_r;
  logic [64:0] a_summ_r;
  logic [63:0] a_alm1_r;
  logic        a_pow2_r;
  logic [63:0] a_start_r;
  logic        a_va_low_r;
  logic        a_va_high_r;
  logic        a_msz_small_r;
  logic [2:0]  a_prot_r;
  logic        a_wx_r;

  logic        b_vld_r;
  esv_pkg::item_t b_item_r;

  logic        a_take;
  logic        b_take;
  logic [63:0] alm1_nxt;
  logic [63:0] va_nxt;
  logic        begin_nxt;

  logic [64:0] au_sum;
  logic [63:0] end_addr;
  esv_pkg::status_t mid_code;
  esv_pkg::status_t late_code;
  esv_pkg::item_t   b_item_nxt;

  assign b_take   = !b_vld_r || q_ready;
  assign a_take   = !a_vld_r || b_take;
  assign in_ready = a_take;
  assign q_valid  = b_vld_r;
  assign q_item   = b_item_r;

  assign begin_nxt = !in_req_type;
  assign alm1_nxt  = in_seg_align - 64'd1;
  assign va_nxt    = begin_nxt ? in_entry_addr : in_seg_vaddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_take) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && in_valid) begin
      a_begin_r     <= begin_nxt;
      a_entry_bad_r <= (in_entry_addr < min_load_addr) || (in_entry_addr >= guest_size);
      a_skip_r      <= (in_seg_filesz == 64'd0) || (in_seg_type != esv_pkg::SEG_TYPE_LOAD);
      a_va_r        <= va_nxt;
      a_sumf_r      <= {1'b0, in_seg_vaddr} + {1'b0, in_seg_filesz};
      a_summ_r      <= {1'b0, in_seg_vaddr} + {1'b0, in_seg_memsz};
      a_alm1_r      <= alm1_nxt;
      a_pow2_r      <= (in_seg_align != 64'd0) && ((in_seg_align & alm1_nxt) == 64'd0);
      a_start_r     <= in_seg_vaddr & ~alm1_nxt;
      a_va_low_r    <= in_seg_vaddr < min_load_addr;
      a_va_high_r   <= in_seg_vaddr >= guest_size;
      a_msz_small_r <= in_seg_memsz < in_seg_filesz;
      a_prot_r      <= {in_seg_flags[0], in_seg_flags[1], in_seg_flags[2]};
      a_wx_r        <= in_seg_flags[1] & in_seg_flags[0];
    end
  end

  // round the memory end up to the segment alignment
  assign au_sum   = {1'b0, a_summ_r[63:0]} + {1'b0, a_alm1_r};
  assign end_addr = au_sum[63:0] & ~a_alm1_r;

  always_comb begin
    priority if (a_va_high_r) begin
      mid_code = esv_pkg::ST_VADDR_HIGH;
    end else if (a_sumf_r[64]) begin
      mid_code = esv_pkg::ST_FILE_OVERFLOW;
    end else if (a_sumf_r[63:0] > guest_size) begin
      mid_code = esv_pkg::ST_FILE_END_HIGH;
    end else if (a_msz_small_r) begin
      mid_code = esv_pkg::ST_MEMSZ_SMALL;
    end else if (a_summ_r[64]) begin
      mid_code = esv_pkg::ST_MEM_OVERFLOW;
    end else if (au_sum[64]) begin
      mid_code = esv_pkg::ST_ALIGNUP_OVERFLOW;
    end else if (end_addr > guest_size) begin
      mid_code = esv_pkg::ST_END_HIGH;
    end else begin
      mid_code = esv_pkg::ST_OK;
    end
  end

  always_comb begin
    priority if ((a_start_r & PAGE_MASK) != 64'd0) begin
      late_code = esv_pkg::ST_START_UNALIGNED;
    end else if ((end_addr & PAGE_MASK) != 64'd0) begin
      late_code = esv_pkg::ST_END_UNALIGNED;
    end else if (a_wx_r) begin
      late_code = esv_pkg::ST_WRITE_EXEC;
    end else begin
      late_code = esv_pkg::ST_OK;
    end
  end

  always_comb begin
    b_item_nxt.is_begin  = a_begin_r;
    b_item_nxt.entry_bad = a_entry_bad_r;
    b_item_nxt.skip      = a_skip_r;
    b_item_nxt.va_low    = a_va_low_r;
    b_item_nxt.align_bad = !a_pow2_r;
    b_item_nxt.start_low = a_start_r < min_load_addr;
    b_item_nxt.addr      = a_va_r;
    b_item_nxt.start     = a_start_r;
    b_item_nxt.end_addr  = end_addr;
    b_item_nxt.mid_code  = mid_code;
    b_item_nxt.late_code = late_code;
    b_item_nxt.prot      = a_prot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_take) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && a_vld_r) begin
      b_item_r <= b_item_nxt;
    end
  end

endmodule

// File: src/esv_queue.sv
// esv_queue: short fifo of classified requests between front and back
// depends on esv_pkg
module esv_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  esv_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output esv_pkg::item_t rd_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  esv_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic           pop;

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: src/esv_back.sv
// esv_back: running image state, final status and the result register
// depends on esv_pkg
module esv_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  esv_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [4:0]     out_status,
  output logic [63:0]    out_region_start,
  output logic [63:0]    out_region_end,
  output logic [2:0]     out_prot,
  output logic [63:0]    out_highest_end,
  output logic [63:0]    out_entry_point
);

  logic [63:0]      last_vaddr_r;
  logic [63:0]      end_so_far_r;
  logic             failed_r;
  logic [63:0]      last_vaddr_nxt;
  logic [63:0]      end_so_far_nxt;
  logic             failed_nxt;

  logic             out_vld_r;
  esv_pkg::status_t out_status_r;
  logic [63:0]      out_start_r;
  logic [63:0]      out_end_r;
  logic [2:0]       out_prot_r;
  logic [63:0]      out_high_r;
  logic [63:0]      out_entry_r;

  esv_pkg::status_t status_nxt;
  logic             pop;

  assign q_ready = !out_vld_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    last_vaddr_nxt = last_vaddr_r;
    end_so_far_nxt = end_so_far_r;
    failed_nxt     = failed_r;
    priority if (q_item.is_begin) begin
      last_vaddr_nxt = '0;
      end_so_far_nxt = '0;
      failed_nxt     = q_item.entry_bad;
      status_nxt     = q_item.entry_bad ? esv_pkg::ST_ENTRY_BAD : esv_pkg::ST_ENTRY_OK;
    end else if (failed_r) begin
      status_nxt = esv_pkg::ST_ALREADY_FAILED;
    end else if (q_item.skip) begin
      status_nxt = esv_pkg::ST_SKIPPED;
    end else if (q_item.va_low) begin
      status_nxt = esv_pkg::ST_VADDR_LOW;
    end else if (q_item.addr < last_vaddr_r) begin
      status_nxt = esv_pkg::ST_UNORDERED;
    end else begin
      // order mark moves as soon as the order check passes
      last_vaddr_nxt = q_item.addr;
      priority if (q_item.align_bad) begin
        status_nxt = esv_pkg::ST_BAD_ALIGN;
      end else if (q_item.start_low) begin
        status_nxt = esv_pkg::ST_START_LOW;
      end else if (q_item.start < end_so_far_r) begin
        status_nxt = esv_pkg::ST_OVERLAP;
      end else if (q_item.mid_code != esv_pkg::ST_OK) begin
        status_nxt = q_item.mid_code;
      end else begin
        if (q_item.end_addr > end_so_far_r) begin
          end_so_far_nxt = q_item.end_addr;
        end
        status_nxt = q_item.late_code;
      end
    end
    if (!q_item.is_begin && status_nxt != esv_pkg::ST_OK && status_nxt != esv_pkg::ST_SKIPPED) begin
      failed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vaddr_r <= '0;
      end_so_far_r <= '0;
      failed_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (pop) begin
        last_vaddr_r <= last_vaddr_nxt;
        end_so_far_r <= end_so_far_nxt;
        failed_r     <= failed_nxt;
      end
      if (q_ready) begin
        out_vld_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status_r <= status_nxt;
      out_start_r  <= (status_nxt == esv_pkg::ST_OK) ? q_item.start : 64'd0;
      out_end_r    <= (status_nxt == esv_pkg::ST_OK) ? q_item.end_addr : 64'd0;
      out_prot_r   <= (status_nxt == esv_pkg::ST_OK) ? q_item.prot : 3'd0;
      out_high_r   <= end_so_far_nxt;
      out_entry_r  <= (status_nxt == esv_pkg::ST_ENTRY_OK) ? q_item.addr : 64'd0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_status_r;
  assign out_region_start = out_start_r;
  assign out_region_end   = out_end_r;
  assign out_prot         = out_prot_r;
  assign out_highest_end  = out_high_r;
  assign out_entry_point  = out_entry_r;

  a_begin_sets_fail: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_item.is_begin |=> failed_r == $past(q_item.entry_bad))
    else $error("failure latch does not follow entry check");

  a_end_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !q_item.is_begin |=> end_so_far_r >= $past(end_so_far_r))
    else $error("highest end dropped without a begin request");

  a_ok_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r == esv_pkg::ST_OK |-> out_start_r < out_end_r)
    else $error("accepted region is empty");

  a_fail_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pop && failed_r && !q_item.is_begin |=> out_status_r == esv_pkg::ST_ALREADY_FAILED)
    else $error("header passed after a latched failure");

endmodule

// File: src/elf_segment_validator_top.sv
// Executable image segment validator. Takes one request per cycle while in_ready is high:
// a begin request with the entry address, then one request per program header. Results
// come back in request order, one per request, on the result ports (the first classify
// stage loads at acceptance, then the second classify stage, the request queue and the
// result register). Sustained rate is one request per clock while out_ready stays high, bounded
// by the back end's update of the running ordering mark, highest end and failure latch.
// Configuration (min load address, memory size) must be written while no request is in flight.
// elf_segment_validator_top: top level; depends on esv_pkg, esv_front, esv_queue, esv_back
module elf_segment_validator_top #(
  parameter int unsigned PAGE_SIZE   = 4096,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [63:0]                   in_entry_addr,
  input  logic [31:0]                   in_seg_type,
  input  logic [31:0]                   in_seg_flags,
  input  logic [63:0]                   in_seg_vaddr,
  input  logic [63:0]                   in_seg_filesz,
  input  logic [63:0]                   in_seg_memsz,
  input  logic [63:0]                   in_seg_align,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_status,
  output logic [63:0]                   out_region_start,
  output logic [63:0]                   out_region_end,
  output logic [2:0]                    out_prot,
  output logic [63:0]                   out_highest_end,
  output logic [63:0]                   out_entry_point,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [esv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  logic [63:0]    min_load_addr_r;
  logic [63:0]    guest_size_r;
  logic           fq_valid;
  logic           fq_ready;
  esv_pkg::item_t fq_item;
  logic           qb_valid;
  logic           qb_ready;
  esv_pkg::item_t qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_load_addr_r <= '0;
      guest_size_r    <= '0;
    end else if (cfg_valid) begin
      unique case (esv_pkg::cfg_idx_t'(cfg_index))
        esv_pkg::CFG_MIN_LOAD_ADDR: min_load_addr_r <= cfg_data;
        esv_pkg::CFG_GUEST_SIZE:    guest_size_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  esv_front #(
    .PAGE_SIZE(PAGE_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_entry_addr(in_entry_addr),
    .in_seg_type  (in_seg_type),
    .in_seg_flags (in_seg_flags),
    .in_seg_vaddr (in_seg_vaddr),
    .in_seg_filesz(in_seg_filesz),
    .in_seg_memsz (in_seg_memsz),
    .in_seg_align (in_seg_align),
    .min_load_addr(min_load_addr_r),
    .guest_size   (guest_size_r),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_item       (fq_item)
  );

  esv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_item (fq_item),
    .rd_valid(qb_valid),
    .rd_ready(qb_ready),
    .rd_item (qb_item)
  );

  esv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (qb_valid),
    .q_ready         (qb_ready),
    .q_item          (qb_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_region_start(out_region_start),
    .out_region_end  (out_region_end),
    .out_prot        (out_prot),
    .out_highest_end (out_highest_end),
    .out_entry_point (out_entry_point)
  );

endmodule
